// ----- src/kslp_pkg.sv -----
// Shared types and constants for the key short/long press detector.
// No dependencies; imported by every module of the block.
package kslp_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned AngleWidth = 32;
  localparam int unsigned CodeWidth  = 3;

  localparam logic [CfgWidth-1:0] LONG_TICKS_RESET = 16'd80;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // key codes, shared by held latch and both reports
  localparam logic [CodeWidth-1:0] CODE_NONE   = 3'd0;
  localparam logic [CodeWidth-1:0] CODE_TOGGLE = 3'd1;
  localparam logic [CodeWidth-1:0] CODE_ENTER  = 3'd2;
  localparam logic [CodeWidth-1:0] CODE_UP     = 3'd3;
  localparam logic [CodeWidth-1:0] CODE_DOWN   = 3'd4;

  typedef struct packed {
    logic                          opcode;
    logic                          btn_enter;
    logic                          btn_toggle;
    logic                          btn_up;
    logic                          btn_down;
    logic signed [AngleWidth-1:0]  angle;
  } kslp_in_t;

  typedef struct packed {
    logic [CodeWidth-1:0]          short_code;
    logic [CodeWidth-1:0]          long_code;
    logic                          quit_request;
    logic                          capture_valid;
    logic signed [AngleWidth-1:0]  captured_angle;
  } kslp_out_t;

endpackage

// ----- src/kslp_core.sv -----
// Press classifier state (latch, tick counter, timer, repeat flag) and its
// single-pass next-state / result logic. Depends on kslp_pkg.
module kslp_core #(
  parameter int unsigned TickBits = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  kslp_pkg::kslp_in_t                item_i,
  input  logic [kslp_pkg::CfgWidth-1:0]     long_ticks_i,
  output kslp_pkg::kslp_out_t               result_o
);
  import kslp_pkg::*;

  localparam int unsigned CmpW = (TickBits > CfgWidth) ? TickBits : CfgWidth;

  logic [CodeWidth-1:0] held_q, held_d;
  logic [TickBits-1:0]  ticks_q, ticks_d;
  logic                 run_q, run_d;
  logic                 rep_q, rep_d;
  logic                 idle;

  always_comb begin
    held_d   = held_q;
    ticks_d  = ticks_q;
    run_d    = run_q;
    rep_d    = rep_q;
    result_o = '0;
    idle     = (held_q == CODE_NONE);

    if (item_i.opcode == OP_TICK) begin
      // saturating count while the timer runs
      if (run_q && (ticks_q != {TickBits{1'b1}})) begin
        ticks_d = ticks_q + TickBits'(1);
      end
    end else begin
      priority if (item_i.btn_enter) begin
        if (idle) begin
          ticks_d = '0;
          run_d   = 1'b1;
          held_d  = CODE_ENTER;
        end
      end else if (item_i.btn_toggle) begin
        if (idle) begin
          ticks_d = '0;
          run_d   = 1'b1;
          held_d  = CODE_TOGGLE;
        end
      end else if (item_i.btn_up || item_i.btn_down) begin
        if (idle) begin
          ticks_d = '0;
          run_d   = 1'b1;
          held_d  = item_i.btn_up ? CODE_UP : CODE_DOWN;
          result_o.capture_valid  = 1'b1;
          result_o.captured_angle = item_i.angle;
        end
      end else if ((ticks_q != '0) || rep_q) begin
        // release
        result_o.short_code = held_q;
        ticks_d = '0;
        run_d   = 1'b0;
        rep_d   = 1'b0;
        held_d  = CODE_NONE;
      end else begin
        // release with nothing counted: latch stays
      end

      // long check sees the count after the key step above
      if (CmpW'(ticks_d) > CmpW'(long_ticks_i)) begin
        result_o.long_code    = held_d;
        result_o.quit_request = (held_d == CODE_ENTER);
        if ((held_d == CODE_UP) || (held_d == CODE_DOWN)) begin
          rep_d = 1'b1;
        end else begin
          held_d = CODE_NONE;
        end
        ticks_d = '0;
        run_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= CODE_NONE;
      ticks_q <= '0;
      run_q   <= 1'b0;
      rep_q   <= 1'b0;
    end else if (fire_i) begin
      held_q  <= held_d;
      ticks_q <= ticks_d;
      run_q   <= run_d;
      rep_q   <= rep_d;
    end
  end

endmodule

// ----- src/key_short_long_press_detector_unit.sv -----
// Key short/long press detector, top level. Depends on kslp_pkg, kslp_core.
// Pipeline: input register, then result register.
// Throughput: one beat per cycle; both stages advance together when the result
// register is empty or being drained.
// Reset (rst_ni, async active low): pipeline empty, no key latched, timer stopped,
// count zero, repeat flag clear, long-press threshold back to 80 ticks.
module key_short_long_press_detector_unit #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  kslp_pkg::kslp_in_t             in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output kslp_pkg::kslp_out_t            out_data_o,
  // threshold register write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kslp_pkg::CfgWidth-1:0]  cfg_data_i
);
  import kslp_pkg::*;

  // Stage 1: registered input beat.
  logic      s1_valid_q;
  kslp_in_t  s1_item_q;
  // Stage 2: registered result beat.
  logic      out_valid_q;
  kslp_out_t out_data_q;
  kslp_out_t result;

  logic [CfgWidth-1:0] long_ticks_q;

  logic advance;   // result register can take a new beat
  logic s1_fire;   // stage 1 beat moves into the classifier

  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  // Threshold register: writes accepted at any time; caller keeps the block idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q <= LONG_TICKS_RESET;
    end else if (cfg_valid_i) begin
      long_ticks_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  // Classifier: state commits when the registered beat moves on.
  kslp_core #(
    .TickBits (TICK_COUNTER_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .item_i       (s1_item_q),
    .long_ticks_i (long_ticks_q),
    .result_o     (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/kslp_checker.sv -----
// Port-level checks for the key press detector, bound to the top level.
// Depends on kslp_pkg and key_short_long_press_detector_unit.
module kslp_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  kslp_pkg::kslp_out_t  out_data_i
);
  import kslp_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // release and long report never in one scan
  a_short_long_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.short_code == CODE_NONE) ||
                    (out_data_i.long_code == CODE_NONE))
    else $error("short and long reported together");

  // quit only with a long enter
  a_quit_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.quit_request |-> out_data_i.long_code == CODE_ENTER)
    else $error("quit without long enter");

  // capture only on a fresh up/down latch, so no report alongside it
  a_capture_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.capture_valid |->
      (out_data_i.short_code == CODE_NONE) && !out_data_i.quit_request)
    else $error("capture beat carries a report");

  a_no_capture_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.capture_valid |-> out_data_i.captured_angle == '0)
    else $error("angle present without capture");

endmodule

bind key_short_long_press_detector_unit kslp_checker u_kslp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ----- tb/sv/press_report_checker.sv -----
// Scoreboard for the key short/long press detector: predicts one report per
// input beat and compares it with the result channel. Depends on kslp_pkg.
`timescale 1ns / 1ps
module press_report_checker #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  kslp_pkg::kslp_in_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  kslp_pkg::kslp_out_t           out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [kslp_pkg::CfgWidth-1:0] cfg_data_i,
  output int                            reports_pending_o,
  output int                            mismatch_count_o
);
  import kslp_pkg::*;

  // shadow of the detector state
  logic [CfgWidth-1:0]          long_ticks;
  logic [CodeWidth-1:0]         held_code;
  logic [TICK_COUNTER_BITS-1:0] press_ticks;
  logic                         timer_on;
  logic                         repeat_armed;

  kslp_out_t expected_reports[$];

  function automatic void restart_timer(input logic [CodeWidth-1:0] code);
    press_ticks = '0;
    timer_on    = 1'b1;
    held_code   = code;
  endfunction

  function automatic kslp_out_t predict_report(input kslp_in_t item);
    kslp_out_t rep;
    logic      was_free;
    rep = '0;
    if (item.opcode == OP_TICK) begin
      if (timer_on && press_ticks != '1) begin
        press_ticks = press_ticks + TICK_COUNTER_BITS'(1);
      end
    end else begin
      was_free = (held_code == CODE_NONE);
      if (item.btn_enter) begin
        if (was_free) restart_timer(CODE_ENTER);
      end else if (item.btn_toggle) begin
        if (was_free) restart_timer(CODE_TOGGLE);
      end else if (item.btn_up || item.btn_down) begin
        if (was_free) begin
          restart_timer(item.btn_up ? CODE_UP : CODE_DOWN);
          rep.capture_valid  = 1'b1;
          rep.captured_angle = item.angle;
        end
      end else if (press_ticks != '0 || repeat_armed) begin
        // release: report short, drop everything
        rep.short_code = held_code;
        press_ticks    = '0;
        timer_on       = 1'b0;
        repeat_armed   = 1'b0;
        held_code      = CODE_NONE;
      end
      if (press_ticks > long_ticks) begin
        rep.long_code    = held_code;
        rep.quit_request = (held_code == CODE_ENTER);
        if (held_code == CODE_UP || held_code == CODE_DOWN) begin
          repeat_armed = 1'b1;
        end else begin
          held_code = CODE_NONE;
        end
        press_ticks = '0;
        timer_on    = 1'b0;
      end
    end
    return rep;
  endfunction

  function automatic int field_error(input string name, input logic [31:0] exp_val,
                                     input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    kslp_out_t want;
    int        errs;
    if (!rst_ni) begin
      long_ticks   = LONG_TICKS_RESET;
      held_code    = CODE_NONE;
      press_ticks  = '0;
      timer_on     = 1'b0;
      repeat_armed = 1'b0;
      expected_reports.delete();
      reports_pending_o <= 0;
      mismatch_count_o  <= 0;
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_i) long_ticks = cfg_data_i;
      if (in_valid_i && in_ready_i) expected_reports.push_back(predict_report(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time,
                   out_data_i);
          errs = 1;
        end else begin
          want = expected_reports.pop_front();
          errs = field_error("short_code", 32'(want.short_code),
                             32'(out_data_i.short_code))
               + field_error("long_code", 32'(want.long_code),
                             32'(out_data_i.long_code))
               + field_error("quit_request", 32'(want.quit_request),
                             32'(out_data_i.quit_request))
               + field_error("capture_valid", 32'(want.capture_valid),
                             32'(out_data_i.capture_valid))
               + field_error("captured_angle", want.captured_angle,
                             out_data_i.captured_angle);
        end
      end
      mismatch_count_o  <= mismatch_count_o + errs;
      reports_pending_o <= expected_reports.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the press detector testbench: clock, reset, stimulus and verdict.
// Depends on kslp_pkg, key_short_long_press_detector_unit, press_report_checker.
`timescale 1ns / 1ps
module testbench;
  import kslp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_BEATS = 320;

  // key masks in the order {enter, toggle, up, down}
  localparam logic [3:0] MASK_NONE   = 4'b0000;
  localparam logic [3:0] MASK_ENTER  = 4'b1000;
  localparam logic [3:0] MASK_TOGGLE = 4'b0100;
  localparam logic [3:0] MASK_UP     = 4'b0010;
  localparam logic [3:0] MASK_DOWN   = 4'b0001;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  kslp_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kslp_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgWidth-1:0] cfg_data  = '0;

  int          reports_pending;
  int          mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned beats_sent  = 0;
  bit          stall_en    = 1'b1;   // random idling on both channels

  always #5 clk = ~clk;

  key_short_long_press_detector_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  press_report_checker report_chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .reports_pending_o (reports_pending),
    .mismatch_count_o  (mismatch_count)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_short_long_press_detector_unit verification failed");
      $finish;
    end
  end

  // Result side back-pressure: ready drops in random bursts while stalling is
  // enabled, otherwise it stays high.
  initial begin : result_stall
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic kslp_in_t make_scan(input logic [3:0] keys, input logic [31:0] angle);
    kslp_in_t item;
    item.opcode = OP_SCAN;
    {item.btn_enter, item.btn_toggle, item.btn_up, item.btn_down} = keys;
    item.angle = angle;
    return item;
  endfunction

  // Ticks ignore keys and angle, so those bits are left random.
  function automatic kslp_in_t make_tick();
    kslp_in_t item;
    item = make_scan(4'($urandom_range(0, 15)), $urandom());
    item.opcode = OP_TICK;
    return item;
  endfunction

  function automatic kslp_in_t random_item();
    kslp_in_t item;
    item = make_scan(4'($urandom_range(0, 15)), $urandom());
    item.opcode = $urandom_range(0, 1) ? OP_SCAN : OP_TICK;
    return item;
  endfunction

  // One input beat. An optional idle gap goes in front while stalling is enabled;
  // valid then stays high until the beat is taken.
  task automatic send_beat(input kslp_in_t item);
    int unsigned gap;
    if (stall_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Wait until every predicted report has come back, then allow for the
  // two-stage pipe to settle.
  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Threshold writes happen only with the pipe empty.
  task automatic write_long_ticks(input logic [CfgWidth-1:0] value);
    wait_reports_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A realistic press: latch, hold for some ticks with held scans mixed in,
  // usually one held scan to catch a long report, then release.
  task automatic press_sequence(input int unsigned thr);
    int unsigned ticks_left;
    send_beat(make_scan(4'($urandom_range(1, 15)), $urandom()));
    if (thr <= 100 && $urandom_range(0, 1)) begin
      ticks_left = thr + 1 + $urandom_range(0, 2);   // past the threshold
    end else begin
      ticks_left = $urandom_range(0, (thr > 40) ? 40 : thr);
    end
    while (ticks_left > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(make_scan(4'($urandom_range(1, 15)), $urandom()));
      end else begin
        send_beat(make_tick());
        ticks_left--;
      end
    end
    if ($urandom_range(0, 3) != 0) send_beat(make_scan(4'($urandom_range(1, 15)), $urandom()));
    send_beat(make_scan(MASK_NONE, $urandom()));
    // sometimes a stray tick and a second release
    if ($urandom_range(0, 3) == 0) begin
      send_beat(make_tick());
      send_beat(make_scan(MASK_NONE, $urandom()));
    end
  endtask

  task automatic random_phase(input logic [CfgWidth-1:0] thr, input int unsigned n_beats);
    int unsigned stop_at;
    write_long_ticks(thr);
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) send_beat(random_item());
      else press_sequence(32'(thr));
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset threshold of 80 ticks.
    send_beat(make_tick());                                 // tick with nothing latched
    send_beat(make_scan(MASK_NONE, $urandom()));            // idle release, no report
    send_beat(make_scan(MASK_ENTER, $urandom()));           // latch enter
    send_beat(make_scan(MASK_TOGGLE | MASK_UP, $urandom())); // ignored while latched
    send_beat(make_scan(MASK_NONE, $urandom()));            // release before any tick
    send_beat(make_tick());
    send_beat(make_scan(MASK_NONE, $urandom()));            // short enter
    send_beat(make_scan(MASK_UP, 32'h8000_0000));           // capture most negative angle
    repeat (81) send_beat(make_tick());
    send_beat(make_scan(MASK_UP, $urandom()));              // long up, repeat armed
    send_beat(make_scan(MASK_DOWN, $urandom()));            // still latched
    send_beat(make_scan(MASK_NONE, $urandom()));            // repeat after long: short up

    // Threshold zero: one tick is already a long press.
    write_long_ticks('0);
    send_beat(make_scan(MASK_DOWN, 32'h7FFF_FFFF));         // capture most positive angle
    send_beat(make_tick());
    send_beat(make_scan(MASK_DOWN, $urandom()));            // long down
    send_beat(make_scan(MASK_NONE, $urandom()));            // short down
    send_beat(make_scan(MASK_TOGGLE, $urandom()));
    send_beat(make_tick());
    send_beat(make_scan(MASK_TOGGLE, $urandom()));          // long toggle drops the latch
    send_beat(make_scan(4'b1111, $urandom()));              // enter wins over the rest
    send_beat(make_tick());
    send_beat(make_scan(MASK_ENTER, $urandom()));           // long enter with quit
    send_beat(make_scan(MASK_UP | MASK_DOWN, 32'hFFFF_FFFF)); // up wins over down
    send_beat(make_scan(MASK_NONE, $urandom()));            // count zero: latch stays
    send_beat(make_tick());
    send_beat(make_scan(MASK_NONE, $urandom()));            // short up

    // Random part, one phase per threshold; idling is on for some phases, off for others.
    random_phase(16'd1, PHASE_BEATS);
    stall_en = 1'b0;
    random_phase(16'd0, PHASE_BEATS);
    stall_en = 1'b1;
    random_phase(16'd80, PHASE_BEATS);
    random_phase(16'($urandom_range(2, 20)), PHASE_BEATS);
    random_phase(16'hFFFF, PHASE_BEATS / 2);
    stall_en = 1'b0;                                        // tail runs without idling
    random_phase(16'd3, PHASE_BEATS);

    wait_reports_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("key_short_long_press_detector_unit verification clean");
    end else begin
      $display("key_short_long_press_detector_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- key_short_long_press_detector_unit.f -----
src/kslp_pkg.sv
src/kslp_core.sv
src/key_short_long_press_detector_unit.sv
src/kslp_checker.sv
tb/sv/press_report_checker.sv
tb/sv/testbench.sv
